// ----- sv/mwcr_pkg.sv -----
package mwcr_pkg;

  // default table capacity per bank
  localparam int MAX_WINDOWS_DEF = 64;

  localparam int ID_W   = 32;
  localparam int COORD_W = 16;
  localparam int AREA_W = 32;
  localparam int CFG_W  = 8;

  // one table row: id, origin x, origin y
  localparam int ROW_W = ID_W + 2 * COORD_W;

  localparam logic [CFG_W-1:0] MIN_DIM_RST = 8'd1;

  // command codes
  localparam logic CMD_WINDOW = 1'b0;
  localparam logic CMD_EOF    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } seq_state_e;

  // status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic is_eof;
    logic skip;
    logic prev_empty;
    logic issue;
    logic hit;
    logic out_free;
  } seq_stat_t;

  // controls driven by the sequencer
  typedef struct packed {
    logic in_stall;
    logic win_take;
    logic scan;
    logic emit;
  } seq_ctrl_t;

endpackage

// ----- sv/mwcr_ram.sv -----
module mwcr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/mwcr_seq.sv -----
module mwcr_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mwcr_pkg::seq_stat_t stat_i,
  output mwcr_pkg::seq_ctrl_t ctrl_o
);

  import mwcr_pkg::*;

  seq_state_e state_q, state_d;
  logic       in_fire;

  assign in_fire = stat_i.in_valid && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (stat_i.is_eof) begin
            state_d = ST_EMIT;
          end else if (!stat_i.skip && !stat_i.prev_empty) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.hit || !stat_i.issue) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o          = '0;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_stall = 1'b0;
        ctrl_o.win_take = in_fire && !stat_i.is_eof && !stat_i.skip;
      end
      ST_SCAN: begin
        ctrl_o.in_stall = 1'b1;
        ctrl_o.scan     = 1'b1;
      end
      ST_EMIT: begin
        ctrl_o.in_stall = 1'b1;
        ctrl_o.emit     = stat_i.out_free;
      end
      default: ctrl_o.in_stall = 1'b1;
    endcase
  end

endmodule

// ----- sv/moved_window_copy_rect_detector.sv -----
// lookup: a skipped window is not looked up; any other window is compared against the P windows
//   stored in the previous frame (one id compared per cycle, none when P is 0), stopping on the first id match
// input is stalled during a scan, so a new item is taken only once the lookup of the last one is done
// end of frame: the sequencer enters its emit state and registers the result word once the output is free
// reset: asynchronous, active low; clears sequencer, counts, bank select, best match and
//   min_dimension (back to 1); table memory is not cleared and needs no clearing pass
module moved_window_copy_rect_detector #(
  parameter int MAX_WINDOWS = mwcr_pkg::MAX_WINDOWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration: min_dimension
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,

  // window list input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [31:0] window_id_i,
  input  logic signed [15:0] win_x_i,
  input  logic signed [15:0] win_y_i,
  input  logic [15:0] win_w_i,
  input  logic [15:0] win_h_i,

  // per-frame result
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        moved_found_o,
  output logic signed [15:0] copy_x_o,
  output logic signed [15:0] copy_y_o,
  output logic [15:0] copy_w_o,
  output logic [15:0] copy_h_o,
  output logic signed [15:0] source_x_o,
  output logic signed [15:0] source_y_o,
  output logic        table_overflow_o
);

  import mwcr_pkg::*;

  // count width holds 0..MAX_WINDOWS, address spans both banks
  localparam int CW    = $clog2(MAX_WINDOWS + 1);
  localparam int DEPTH = 2 * MAX_WINDOWS;
  localparam int AW    = $clog2(DEPTH);

  seq_stat_t stat;
  seq_ctrl_t ctrl;

  // config register
  logic [CFG_W-1:0] min_dim_q;

  // bank bookkeeping
  logic          bank_q;
  logic [CW-1:0] prev_count_q;
  logic [CW-1:0] new_count_q;
  logic          overflow_q;

  // window under lookup
  logic [ID_W-1:0]          id_q;
  logic signed [COORD_W-1:0] x_q, y_q;
  logic [COORD_W-1:0]       w_q, h_q;
  logic [AREA_W-1:0]        area_q;

  // scan pointer and read pipeline flag
  logic [CW-1:0] idx_q, idx_d;
  logic          rd_vld_q, rd_vld_d;

  // best match so far in this frame
  logic signed [COORD_W-1:0] best_x_q, best_y_q;
  logic [COORD_W-1:0]        best_w_q, best_h_q;
  logic [AREA_W-1:0]         best_area_q;
  logic signed [COORD_W-1:0] best_src_x_q, best_src_y_q;

  // output word register
  logic out_valid_q;
  logic moved_found_q, table_overflow_q;
  logic signed [COORD_W-1:0] copy_x_q, copy_y_q, source_x_q, source_y_q;
  logic [COORD_W-1:0] copy_w_q, copy_h_q;

  // table memory access
  logic          ram_we;
  logic [AW-1:0] cur_base, old_base, ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;
  logic [ID_W-1:0]  rd_id;
  logic signed [COORD_W-1:0] rd_x, rd_y;

  logic skip, room, issue, hit, moved, better, out_free;

  // configuration is taken any time; the user writes it only while idle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dim_q <= MIN_DIM_RST;
    end else if (cfg_valid_i) begin
      min_dim_q <= cfg_data_i;
    end
  end

  // a window at or below the minimum size in either direction is dropped
  assign skip = (win_w_i <= {8'd0, min_dim_q}) || (win_h_i <= {8'd0, min_dim_q});
  assign room = new_count_q < CW'(MAX_WINDOWS);

  // bank_q selects the half being filled this frame
  assign cur_base  = bank_q ? AW'(MAX_WINDOWS) : '0;
  assign old_base  = bank_q ? '0 : AW'(MAX_WINDOWS);
  assign ram_we    = ctrl.win_take && room;
  assign ram_waddr = cur_base + AW'(new_count_q);
  assign ram_wdata = {window_id_i, win_x_i, win_y_i};
  assign ram_raddr = old_base + AW'(idx_q);

  mwcr_ram #(
    .WIDTH(ROW_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_id = ram_rdata[ROW_W-1 -: ID_W];
  assign rd_x  = ram_rdata[2*COORD_W-1 -: COORD_W];
  assign rd_y  = ram_rdata[COORD_W-1:0];

  // scan issues one read per cycle until an id match; the compare lands in the next cycle, on the registered table read
  assign issue  = idx_q < prev_count_q;
  assign hit    = rd_vld_q && (rd_id == id_q);
  assign moved  = (rd_x != x_q) || (rd_y != y_q);
  assign better = area_q > best_area_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    stat            = '0;
    stat.in_valid   = in_valid_i;
    stat.is_eof     = (cmd_i == CMD_EOF);
    stat.skip       = skip;
    stat.prev_empty = (prev_count_q == '0);
    stat.issue      = issue;
    stat.hit        = hit;
    stat.out_free   = out_free;
  end

  mwcr_seq u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .ctrl_o(ctrl)
  );

  assign in_stall_o = ctrl.in_stall;

  // scan pointer: restarts on each window taken for lookup, stops on first id match
  always_comb begin
    idx_d    = idx_q;
    rd_vld_d = 1'b0;
    if (ctrl.win_take) begin
      idx_d = '0;
    end else if (ctrl.scan && issue && !hit) begin
      idx_d    = idx_q + 1'b1;
      rd_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  // latch the window and its area (single 16x16 multiply)
  always_ff @(posedge clk_i) begin
    if (ctrl.win_take) begin
      id_q   <= window_id_i;
      x_q    <= win_x_i;
      y_q    <= win_y_i;
      w_q    <= win_w_i;
      h_q    <= win_h_i;
      area_q <= AREA_W'(win_w_i) * AREA_W'(win_h_i);
    end
  end

  // table fill, overflow, bank swap and best-match tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q       <= 1'b0;
      prev_count_q <= '0;
      new_count_q  <= '0;
      overflow_q   <= 1'b0;
      best_x_q     <= '0;
      best_y_q     <= '0;
      best_w_q     <= '0;
      best_h_q     <= '0;
      best_area_q  <= '0;
      best_src_x_q <= '0;
      best_src_y_q <= '0;
    end else if (ctrl.emit) begin
      bank_q       <= ~bank_q;
      prev_count_q <= new_count_q;
      new_count_q  <= '0;
      overflow_q   <= 1'b0;
      best_x_q     <= '0;
      best_y_q     <= '0;
      best_w_q     <= '0;
      best_h_q     <= '0;
      best_area_q  <= '0;
      best_src_x_q <= '0;
      best_src_y_q <= '0;
    end else begin
      if (ctrl.win_take) begin
        if (room) begin
          new_count_q <= new_count_q + 1'b1;
        end else begin
          // full table: not stored but still looked up
          overflow_q <= 1'b1;
        end
      end
      // strict compare keeps the earlier window on equal area
      if (ctrl.scan && hit && moved && better) begin
        best_x_q     <= x_q;
        best_y_q     <= y_q;
        best_w_q     <= w_q;
        best_h_q     <= h_q;
        best_area_q  <= area_q;
        best_src_x_q <= rd_x;
        best_src_y_q <= rd_y;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      moved_found_q    <= (best_area_q != '0);
      copy_x_q         <= best_x_q;
      copy_y_q         <= best_y_q;
      copy_w_q         <= best_w_q;
      copy_h_q         <= best_h_q;
      source_x_q       <= best_src_x_q;
      source_y_q       <= best_src_y_q;
      table_overflow_q <= overflow_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign moved_found_o    = moved_found_q;
  assign copy_x_o         = copy_x_q;
  assign copy_y_o         = copy_y_q;
  assign copy_w_o         = copy_w_q;
  assign copy_h_o         = copy_h_q;
  assign source_x_o       = source_x_q;
  assign source_y_o       = source_y_q;
  assign table_overflow_o = table_overflow_q;

`ifndef SYNTHESIS
  // fill count never passes the bank size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    new_count_q <= CW'(MAX_WINDOWS))
    else $error("new_count above capacity");

  // scan pointer stays within the previous frame's entries
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.scan |-> idx_q <= prev_count_q)
    else $error("scan pointer past previous count");

  // a pending compare only follows a scan cycle
  a_rd_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(ctrl.scan))
    else $error("compare without a scan read");

  // an emitted frame result shows up as a valid word
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |=> out_valid_q)
    else $error("frame result lost");
`endif

endmodule

// ----- tb/sv/mwcr_frame_checker.sv -----
module mwcr_frame_checker #(
  parameter int MAX_WINDOWS = mwcr_pkg::MAX_WINDOWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               cmd_i,
  input  logic [31:0]        window_id_i,
  input  logic signed [15:0] win_x_i,
  input  logic signed [15:0] win_y_i,
  input  logic [15:0]        win_w_i,
  input  logic [15:0]        win_h_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               moved_found_i,
  input  logic signed [15:0] copy_x_i,
  input  logic signed [15:0] copy_y_i,
  input  logic [15:0]        copy_w_i,
  input  logic [15:0]        copy_h_i,
  input  logic signed [15:0] source_x_i,
  input  logic signed [15:0] source_y_i,
  input  logic               table_overflow_i,
  output int                 err_count_o,
  output int                 pending_o
);
  import mwcr_pkg::*;

  typedef struct {
    logic               moved_found;
    logic signed [15:0] copy_x;
    logic signed [15:0] copy_y;
    logic [15:0]        copy_w;
    logic [15:0]        copy_h;
    logic signed [15:0] source_x;
    logic signed [15:0] source_y;
    logic               table_overflow;
  } copy_rect_t;

  logic [ID_W-1:0]    bank_id [2][MAX_WINDOWS];
  logic [COORD_W-1:0] bank_x  [2][MAX_WINDOWS];
  logic [COORD_W-1:0] bank_y  [2][MAX_WINDOWS];
  logic               fill_bank;
  int                 prev_n;
  int                 new_n;
  copy_rect_t         best;
  logic [AREA_W-1:0]  best_area;
  logic [CFG_W-1:0]   min_dim;
  copy_rect_t         copy_rect_q[$];
  int                 errs = 0;

  task automatic clear_best();
    best.moved_found    = 1'b0;
    best.copy_x         = '0;
    best.copy_y         = '0;
    best.copy_w         = '0;
    best.copy_h         = '0;
    best.source_x       = '0;
    best.source_y       = '0;
    best.table_overflow = 1'b0;
    best_area           = '0;
  endtask

  task automatic track_window();
    logic [AREA_W-1:0] area;
    logic              hit;
    area = AREA_W'(win_w_i) * AREA_W'(win_h_i);
    hit  = 1'b0;
    if (win_w_i > 16'(min_dim) && win_h_i > 16'(min_dim)) begin
      if (new_n < MAX_WINDOWS) begin
        bank_id[fill_bank][new_n] = window_id_i;
        bank_x[fill_bank][new_n]  = win_x_i;
        bank_y[fill_bank][new_n]  = win_y_i;
        new_n++;
      end else begin
        best.table_overflow = 1'b1;
      end
      // first matching id of the previous frame decides
      for (int i = 0; i < prev_n && !hit; i++) begin
        if (bank_id[!fill_bank][i] == window_id_i) begin
          hit = 1'b1;
          if ((bank_x[!fill_bank][i] != win_x_i || bank_y[!fill_bank][i] != win_y_i)
              && area > best_area) begin
            best.copy_x   = win_x_i;
            best.copy_y   = win_y_i;
            best.copy_w   = win_w_i;
            best.copy_h   = win_h_i;
            best.source_x = bank_x[!fill_bank][i];
            best.source_y = bank_y[!fill_bank][i];
            best_area     = area;
          end
        end
      end
    end
  endtask

  task automatic close_frame();
    best.moved_found = (best_area != '0);
    copy_rect_q.push_back(best);
    fill_bank = !fill_bank;
    prev_n    = new_n;
    new_n     = 0;
    clear_best();
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  task automatic check_result();
    copy_rect_t want;
    if (copy_rect_q.size() == 0) begin
      $error("result word with no frame closed");
      errs++;
    end else begin
      want = copy_rect_q.pop_front();
      check_field("moved_found", want.moved_found, moved_found_i);
      check_field("copy_x", want.copy_x, copy_x_i);
      check_field("copy_y", want.copy_y, copy_y_i);
      check_field("copy_w", want.copy_w, copy_w_i);
      check_field("copy_h", want.copy_h, copy_h_i);
      check_field("source_x", want.source_x, source_x_i);
      check_field("source_y", want.source_y, source_y_i);
      check_field("table_overflow", want.table_overflow, table_overflow_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_bank = 1'b0;
      prev_n    = 0;
      new_n     = 0;
      min_dim   = MIN_DIM_RST;
      clear_best();
      copy_rect_q.delete();
      pending_o <= 0;
    end else begin
      // a result word here always stems from an earlier end of frame
      if (out_valid_i && !out_stall_i) begin
        check_result();
      end
      if (cfg_valid_i && cfg_ready_i) begin
        min_dim = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == CMD_EOF) begin
          close_frame();
        end else begin
          track_window();
        end
      end
      pending_o <= copy_rect_q.size();
    end
    err_count_o <= errs;
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import mwcr_pkg::*;

  // longest stretch with no word moving on any channel
  localparam int QUIET_LIMIT  = 2000;
  // a looked-up window scans up to MAX_WINDOWS ids; the drain covers such a scan
  localparam int DRAIN_CYCLES = MAX_WINDOWS_DEF + 16;
  // random items per configuration phase
  localparam int PHASE_ITEMS  = 120;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data   = '0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic               cmd        = CMD_WINDOW;
  logic [31:0]        window_id  = '0;
  logic signed [15:0] win_x      = '0;
  logic signed [15:0] win_y      = '0;
  logic [15:0]        win_w      = '0;
  logic [15:0]        win_h      = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic               moved_found;
  logic signed [15:0] copy_x;
  logic signed [15:0] copy_y;
  logic [15:0]        copy_w;
  logic [15:0]        copy_h;
  logic signed [15:0] source_x;
  logic signed [15:0] source_y;
  logic               table_overflow;
  int                 err_count;
  int                 pending;

  // idle chances in percent for the two sides
  int send_pct = 0;
  int recv_pct = 0;
  int quiet    = 0;
  int frame_no = 0;
  int sent_in_phase = 0;

  // windows of the frame being sent and of the one before
  logic [31:0] prev_id[$];
  logic [15:0] prev_x[$];
  logic [15:0] prev_y[$];
  logic [31:0] cur_id[$];
  logic [15:0] cur_x[$];
  logic [15:0] cur_y[$];
  logic [15:0] last_w = 16'd3;
  logic [15:0] last_h = 16'd3;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  moved_window_copy_rect_detector dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .cmd_i            (cmd),
    .window_id_i      (window_id),
    .win_x_i          (win_x),
    .win_y_i          (win_y),
    .win_w_i          (win_w),
    .win_h_i          (win_h),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .moved_found_o    (moved_found),
    .copy_x_o         (copy_x),
    .copy_y_o         (copy_y),
    .copy_w_o         (copy_w),
    .copy_h_o         (copy_h),
    .source_x_o       (source_x),
    .source_y_o       (source_y),
    .table_overflow_o (table_overflow)
  );

  mwcr_frame_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .cmd_i            (cmd),
    .window_id_i      (window_id),
    .win_x_i          (win_x),
    .win_y_i          (win_y),
    .win_w_i          (win_w),
    .win_h_i          (win_h),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .moved_found_i    (moved_found),
    .copy_x_i         (copy_x),
    .copy_y_i         (copy_y),
    .copy_w_i         (copy_w),
    .copy_h_i         (copy_h),
    .source_x_i       (source_x),
    .source_y_i       (source_y),
    .table_overflow_i (table_overflow),
    .err_count_o      (err_count),
    .pending_o        (pending)
  );

  // result side backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_pct);
  end

  // watchdog on cycles where no word moves anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after the word went in,
  // with valid still high so a back-to-back word needs no second assignment
  task automatic send_item(input logic c, input logic [31:0] id, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] w, input logic [15:0] h);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    window_id <= id;
    win_x     <= x;
    win_y     <= y;
    win_w     <= w;
    win_h     <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_in_phase++;
  endtask

  task automatic send_window(input logic [31:0] id, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] w, input logic [15:0] h);
    send_item(CMD_WINDOW, id, x, y, w, h);
    cur_id.push_back(id);
    cur_x.push_back(x);
    cur_y.push_back(y);
    last_w = w;
    last_h = h;
  endtask

  // end of frame carries junk in the other fields, the block ignores it
  task automatic send_eof();
    send_item(CMD_EOF, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
    prev_id = cur_id;
    prev_x  = cur_x;
    prev_y  = cur_y;
    cur_id.delete();
    cur_x.delete();
    cur_y.delete();
  endtask

  // drop valid, let every frame result come out, then give the scan time to finish
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_min_dim(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly sizes that get stored, some at or below the threshold
  function automatic logic [15:0] pick_dim(input int md, input int skip_pct);
    if ($urandom_range(0, 99) < skip_pct) begin
      return 16'($urandom_range(0, md));
    end
    case ($urandom_range(0, 5))
      0:       return 16'(md + 1);
      1:       return 16'($urandom);
      2:       return 16'hFFFF;
      default: return 16'(md + 1 + $urandom_range(0, 300));
    endcase
  endfunction

  // one window list: ids mostly carried over from the last frame, moved or not,
  // some repeated within the frame, some fresh; now and then past table capacity
  task automatic random_frame(input int md);
    int          n;
    int          r;
    int          k;
    bit          big;
    logic [31:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    big = (frame_no % 20 == 3) || ($urandom_range(0, 99) < 3);
    n   = big ? $urandom_range(MAX_WINDOWS_DEF + 2, MAX_WINDOWS_DEF + 16)
              : $urandom_range(0, 14);
    repeat (n) begin
      r = $urandom_range(0, 99);
      x = 16'($urandom);
      y = 16'($urandom);
      if (r < 60 && prev_id.size() > 0) begin
        k  = $urandom_range(0, prev_id.size() - 1);
        id = prev_id[k];
        x  = prev_x[k];
        y  = prev_y[k];
        case ($urandom_range(0, 5))
          0: x = x + 16'($urandom_range(1, 3));
          1: y = y - 16'($urandom_range(1, 3));
          2: begin
            x = 16'($urandom);
            y = 16'($urandom);
          end
          3: x = ~x;
          default: ;
        endcase
      end else if (r < 70 && cur_id.size() > 0) begin
        id = cur_id[$urandom_range(0, cur_id.size() - 1)];
      end else begin
        id = $urandom;
      end
      // swapped sizes of the last window give an equal area
      if ($urandom_range(0, 99) < 15) begin
        w = last_h;
        h = last_w;
      end else begin
        w = pick_dim(md, big ? 1 : 10);
        h = pick_dim(md, big ? 1 : 10);
      end
      send_window(id, x, y, w, h);
    end
    send_eof();
    frame_no++;
  endtask

  initial begin : stimulus
    int md;
    send_pct = 35;
    recv_pct = 75;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames at the reset threshold of one
    // empty previous table
    send_eof();
    send_window(32'h11, 16'd100, 16'd200, 16'd40, 16'd30);
    send_window(32'h22, 16'h8000, 16'h7FFF, 16'd30, 16'd40);
    send_window(32'h33, 16'd5, 16'd5, 16'd500, 16'd500);
    // same id twice, first copy must win on lookup
    send_window(32'hFFFF_FFFF, 16'd0, 16'd0, 16'd2, 16'd2);
    send_window(32'hFFFF_FFFF, 16'd7, 16'd7, 16'd2, 16'd2);
    // width or height at or below the threshold is skipped
    send_window(32'h0, 16'd9, 16'd9, 16'd1, 16'd50);
    send_window(32'h44, 16'd9, 16'd9, 16'd50, 16'd0);
    send_eof();
    // two moves of equal area, earlier one kept, then a bigger one
    send_window(32'h11, 16'd101, 16'd200, 16'd40, 16'd30);
    send_window(32'h22, 16'h7FFF, 16'h8000, 16'd30, 16'd40);
    // unmoved and large, never chosen; then the bigger move of the repeated id
    send_window(32'h33, 16'd5, 16'd5, 16'd500, 16'd500);
    send_window(32'hFFFF_FFFF, 16'd7, 16'd7, 16'd2000, 16'd2000);
    send_window(32'h8000_0000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
    // moved but skipped
    send_window(32'h33, 16'd1, 16'd1, 16'd1, 16'd900);
    send_window(32'h44, 16'd0, 16'd0, 16'd0, 16'd0);
    send_eof();
    // largest possible area from one corner to the other
    send_window(32'h8000_0000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    send_window(32'h11, 16'd101, 16'd200, 16'd40, 16'd30);
    send_eof();

    // random phases, each under its own threshold; the idle pattern changes at phases 2 and 4
    for (int ph = 0; ph < 6; ph++) begin
      quiesce();
      case (ph)
        0:       md = 0;
        1:       md = 255;
        3:       md = MIN_DIM_RST;
        4:       md = $urandom_range(2, 16);
        default: md = $urandom_range(0, 255);
      endcase
      if (ph == 2) begin
        send_pct = 75;
        recv_pct = 35;
      end
      if (ph == 4) begin
        send_pct = 0;
        recv_pct = 0;
      end
      write_min_dim(8'(md));
      sent_in_phase = 0;
      while (sent_in_phase < PHASE_ITEMS) random_frame(md);
    end

    quiesce();
    if (err_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
